// ----- hw/rtl/vector3_arith_normalize_defines.svh -----
// ----------------------------------------------------------------------------
// vector3 arith normalize assertion macros
// shared concurrent assertion forms for the vector unit
// ----------------------------------------------------------------------------
`ifndef VECTOR3_ARITH_NORMALIZE_DEFINES_SVH
`define VECTOR3_ARITH_NORMALIZE_DEFINES_SVH

// checked only out of reset
`define V3N_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define V3N_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/v3n_pkg.sv -----
// ----------------------------------------------------------------------------
// v3n_pkg
// types and constants shared by the vector unit
// ----------------------------------------------------------------------------
package v3n_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int SUM_W     = 2 * WORD_W;
  localparam int QUO_W     = FRAC_W + 1;
  localparam int LANES     = 3;

  localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_MAG   = 3'd3,
    OP_NORM  = 3'd4
  } v3n_op_t;

  typedef logic [LANES-1:0][WORD_W-1:0] vec_t;

  typedef struct packed {
    logic [2:0]       op;
    vec_t             am;
    logic [LANES-1:0] an;
    vec_t             res;
    logic             sat;
  } v3n_pay_t;

  typedef logic [LANES-1:0][QUO_W-1:0] quo_t;

endpackage

// ----- hw/rtl/v3n_front.sv -----
// ----------------------------------------------------------------------------
// v3n_front
// two-stage front end: add/sub/scale with saturation, sum of squares
// ----------------------------------------------------------------------------
module v3n_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [2:0]        in_op,
  input  v3n_pkg::vec_t     in_a,
  input  v3n_pkg::vec_t     in_b,
  input  logic [v3n_pkg::WORD_W-1:0] in_s,
  output logic              out_v,
  output logic [v3n_pkg::SUM_W-1:0] out_sum,
  output v3n_pkg::v3n_pay_t out_pay
);

  localparam int W = v3n_pkg::WORD_W;
  localparam int S = v3n_pkg::SUM_W;
  localparam int L = v3n_pkg::LANES;

  logic [L-1:0][W-1:0] am_c, ar_c;
  logic [L-1:0]        an_c, ao_c;
  logic [L-1:0][S-1:0] pr_c, sq_c;
  logic [W-1:0]        sm_c;
  logic                sn_c;
  logic [L-1:0][W:0]   es_c;

  logic                v1_r;
  logic [2:0]          op1_r;
  logic [L-1:0][W-1:0] am1_r, ar1_r;
  logic [L-1:0]        an1_r;
  logic                sn1_r, as1_r;
  logic [L-1:0][S-1:0] pr1_r, sq1_r;

  logic [L-1:0][S-1:0] q_c;
  logic [L-1:0][W-1:0] sv_c;
  logic [L-1:0]        ss_c;
  logic [S-1:0]        sum_c;
  v3n_pkg::v3n_pay_t   pay_c;

  logic                v2_r;
  logic [S-1:0]        sum2_r;
  v3n_pkg::v3n_pay_t   pay2_r;

  always_comb begin
    sn_c = in_s[W-1];
    sm_c = sn_c ? (~in_s + W'(1)) : in_s;
    for (int i = 0; i < L; i++) begin
      an_c[i] = in_a[i][W-1];
      am_c[i] = an_c[i] ? (~in_a[i] + W'(1)) : in_a[i];
      pr_c[i] = S'(am_c[i]) * S'(sm_c);
      sq_c[i] = S'(am_c[i]) * S'(am_c[i]);
      if (in_op == v3n_pkg::OP_SUB) begin
        es_c[i] = {in_a[i][W-1], in_a[i]} - {in_b[i][W-1], in_b[i]};
      end else begin
        es_c[i] = {in_a[i][W-1], in_a[i]} + {in_b[i][W-1], in_b[i]};
      end
      ao_c[i] = es_c[i][W] ^ es_c[i][W-1];
      if (ao_c[i]) begin
        ar_c[i] = es_c[i][W] ? v3n_pkg::WORD_MIN : v3n_pkg::WORD_MAX;
      end else begin
        ar_c[i] = es_c[i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= in_op;
      am1_r <= am_c;
      an1_r <= an_c;
      ar1_r <= ar_c;
      as1_r <= |ao_c;
      sn1_r <= sn_c;
      pr1_r <= pr_c;
      sq1_r <= sq_c;
    end
  end

  always_comb begin
    sum_c = sq1_r[0] + sq1_r[1] + sq1_r[2];
    for (int i = 0; i < L; i++) begin
      q_c[i]  = pr1_r[i] >> v3n_pkg::FRAC_W;
      if (an1_r[i] ^ sn1_r) begin
        ss_c[i] = q_c[i] > S'(v3n_pkg::WORD_MIN);
        sv_c[i] = ss_c[i] ? v3n_pkg::WORD_MIN : (~q_c[i][W-1:0] + W'(1));
      end else begin
        ss_c[i] = q_c[i] > S'(v3n_pkg::WORD_MAX);
        sv_c[i] = ss_c[i] ? v3n_pkg::WORD_MAX : q_c[i][W-1:0];
      end
    end
    pay_c.op = op1_r;
    pay_c.am = am1_r;
    pay_c.an = an1_r;
    case (op1_r)
      v3n_pkg::OP_ADD, v3n_pkg::OP_SUB: begin
        pay_c.res = ar1_r;
        pay_c.sat = as1_r;
      end
      v3n_pkg::OP_SCALE: begin
        pay_c.res = sv_c;
        pay_c.sat = |ss_c;
      end
      default: begin
        pay_c.res = '0;
        pay_c.sat = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum2_r <= sum_c;
      pay2_r <= pay_c;
    end
  end

  assign out_v   = v2_r;
  assign out_sum = sum2_r;
  assign out_pay = pay2_r;

endmodule

// ----- hw/rtl/v3n_sqrt.sv -----
// ----------------------------------------------------------------------------
// v3n_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module v3n_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [v3n_pkg::SUM_W-1:0] in_sum,
  input  v3n_pkg::v3n_pay_t in_pay,
  output logic              out_v,
  output logic [v3n_pkg::WORD_W-1:0] out_root,
  output v3n_pkg::v3n_pay_t out_pay
);

  localparam int W = v3n_pkg::WORD_W;
  localparam int S = v3n_pkg::SUM_W;

  logic              v_r    [W];
  logic [W:0]        rem_r  [W];
  logic [W-1:0]      root_r [W];
  logic [S-1:0]      rad_r  [W];
  v3n_pkg::v3n_pay_t pay_r  [W];

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic              pv;
    logic [W:0]        prem;
    logic [W-1:0]      proot;
    logic [S-1:0]      prad;
    v3n_pkg::v3n_pay_t ppay;
    logic [W+2:0]      cur, trial, diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign pv    = in_v;
      assign prem  = '0;
      assign proot = '0;
      assign prad  = in_sum;
      assign ppay  = in_pay;
    end else begin : g_next
      assign pv    = v_r[i-1];
      assign prem  = rem_r[i-1];
      assign proot = root_r[i-1];
      assign prad  = rad_r[i-1];
      assign ppay  = pay_r[i-1];
    end

    assign cur   = {prem, prad[S-1 -: 2]};
    assign trial = {1'b0, proot, 2'b01};
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? diff[W:0] : cur[W:0];
        root_r[i] <= {proot[W-2:0], ge};
        rad_r[i]  <= prad << 2;
        pay_r[i]  <= ppay;
      end
    end
  end

  assign out_v    = v_r[W-1];
  assign out_root = root_r[W-1];
  assign out_pay  = pay_r[W-1];

endmodule

// ----- hw/rtl/v3n_div.sv -----
// ----------------------------------------------------------------------------
// v3n_div
// pipelined restoring divider, one quotient bit per stage on three lanes
// ----------------------------------------------------------------------------
module v3n_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [v3n_pkg::WORD_W-1:0] in_len,
  input  v3n_pkg::v3n_pay_t in_pay,
  output logic              out_v,
  output logic [v3n_pkg::WORD_W-1:0] out_len,
  output v3n_pkg::quo_t     out_quo,
  output v3n_pkg::v3n_pay_t out_pay
);

  localparam int W = v3n_pkg::WORD_W;
  localparam int Q = v3n_pkg::QUO_W;
  localparam int L = v3n_pkg::LANES;

  logic                v_r   [Q];
  logic [L-1:0][W:0]   rem_r [Q];
  v3n_pkg::quo_t       quo_r [Q];
  logic [W-1:0]        len_r [Q];
  v3n_pkg::v3n_pay_t   pay_r [Q];

  for (genvar i = 0; i < Q; i++) begin : g_stage
    logic                pv;
    v3n_pkg::quo_t       pquo;
    logic [W-1:0]        plen;
    v3n_pkg::v3n_pay_t   ppay;
    logic [L-1:0][W:0]   cur, nrem;
    v3n_pkg::quo_t       nquo;

    if (i == 0) begin : g_first
      assign pv   = in_v;
      assign pquo = '0;
      assign plen = in_len;
      assign ppay = in_pay;
      for (genvar l = 0; l < L; l++) begin : g_ld
        assign cur[l]  = {1'b0, in_pay.am[l]};
      end
    end else begin : g_next
      assign pv   = v_r[i-1];
      assign pquo = quo_r[i-1];
      assign plen = len_r[i-1];
      assign ppay = pay_r[i-1];
      for (genvar l = 0; l < L; l++) begin : g_ld
        assign cur[l]  = {rem_r[i-1][l][W-1:0], 1'b0};
      end
    end

    always_comb begin
      for (int l = 0; l < L; l++) begin
        if (cur[l] >= {1'b0, plen}) begin
          nrem[l] = cur[l] - {1'b0, plen};
          nquo[l] = {pquo[l][Q-2:0], 1'b1};
        end else begin
          nrem[l] = cur[l];
          nquo[l] = {pquo[l][Q-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= nrem;
        quo_r[i] <= nquo;
        len_r[i] <= plen;
        pay_r[i] <= ppay;
      end
    end
  end

  assign out_v   = v_r[Q-1];
  assign out_len = len_r[Q-1];
  assign out_quo = quo_r[Q-1];
  assign out_pay = pay_r[Q-1];

endmodule

// ----- hw/rtl/vector3_arith_normalize.sv -----
// Three-component Q16.16 vector unit: add, subtract, scale (all saturating),
// magnitude and normalize. It takes one transaction per clock unless stalled
// and returns each result through two front stages (saturating add/sub, 32x32
// products and the sum of squares), 32 square-root stages at one root bit
// each, 17 divider stages at one quotient bit each, and the output register.
// The whole pipeline advances together; a valid result held by out_stall
// freezes every stage and raises in_stall. Normalizing a zero vector returns
// zero with zero_vector set.
// ----------------------------------------------------------------------------
// vector3_arith_normalize
// top level: pipeline control, result select and output register
// ----------------------------------------------------------------------------
`include "vector3_arith_normalize_defines.svh"

module vector3_arith_normalize (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_a_x,
  input  logic [31:0] in_a_y,
  input  logic [31:0] in_a_z,
  input  logic [31:0] in_b_x,
  input  logic [31:0] in_b_y,
  input  logic [31:0] in_b_z,
  input  logic [31:0] in_scale_factor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_res_x,
  output logic [31:0] out_res_y,
  output logic [31:0] out_res_z,
  output logic [31:0] out_length,
  output logic        out_saturated,
  output logic        out_zero_vector
);

  localparam int W = v3n_pkg::WORD_W;
  localparam int Q = v3n_pkg::QUO_W;
  localparam int L = v3n_pkg::LANES;

  logic              en;
  v3n_pkg::vec_t     a_c, b_c;
  logic              fv, sv, dv;
  logic [v3n_pkg::SUM_W-1:0] fsum;
  v3n_pkg::v3n_pay_t fpay, spay, dpay;
  logic [W-1:0]      sroot, dlen;
  v3n_pkg::quo_t     dquo;

  v3n_pkg::vec_t     res_nxt, res_r;
  logic [W-1:0]      len_nxt, len_r;
  logic              sat_nxt, sat_r, zero_nxt, zero_r;
  logic              out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign a_c = {in_a_z, in_a_y, in_a_x};
  assign b_c = {in_b_z, in_b_y, in_b_x};

  v3n_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (in_valid),
    .in_op   (in_req_type),
    .in_a    (a_c),
    .in_b    (b_c),
    .in_s    (in_scale_factor),
    .out_v   (fv),
    .out_sum (fsum),
    .out_pay (fpay)
  );

  v3n_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (fv),
    .in_sum   (fsum),
    .in_pay   (fpay),
    .out_v    (sv),
    .out_root (sroot),
    .out_pay  (spay)
  );

  v3n_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (sv),
    .in_len  (sroot),
    .in_pay  (spay),
    .out_v   (dv),
    .out_len (dlen),
    .out_quo (dquo),
    .out_pay (dpay)
  );

  always_comb begin
    res_nxt  = '0;
    len_nxt  = '0;
    sat_nxt  = 1'b0;
    zero_nxt = 1'b0;
    case (dpay.op)
      v3n_pkg::OP_ADD, v3n_pkg::OP_SUB, v3n_pkg::OP_SCALE: begin
        res_nxt = dpay.res;
        sat_nxt = dpay.sat;
      end
      v3n_pkg::OP_MAG: begin
        len_nxt = dlen;
      end
      v3n_pkg::OP_NORM: begin
        len_nxt = dlen;
        if (dlen == '0) begin
          zero_nxt = 1'b1;
        end else begin
          for (int i = 0; i < L; i++) begin
            if (dpay.an[i]) begin
              res_nxt[i] = ~{{(W-Q){1'b0}}, dquo[i]} + W'(1);
            end else begin
              res_nxt[i] = {{(W-Q){1'b0}}, dquo[i]};
            end
          end
        end
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      len_r  <= len_nxt;
      sat_r  <= sat_nxt;
      zero_r <= zero_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_res_x       = res_r[0];
  assign out_res_y       = res_r[1];
  assign out_res_z       = res_r[2];
  assign out_length      = len_r;
  assign out_saturated   = sat_r;
  assign out_zero_vector = zero_r;

  `V3N_ASSERT_ALWAYS(a_rst_clears, !rst_n |=> !out_valid, "output valid after reset")
  `V3N_ASSERT(a_stall_ctl, in_stall == (out_valid && out_stall), "input stall mismatch")
  `V3N_ASSERT(a_zero_len, out_valid && out_zero_vector |-> out_length == '0, "zero flag with length")
  `V3N_ASSERT(a_flag_excl, out_valid |-> !(out_saturated && out_zero_vector), "both flags set")
  `V3N_ASSERT(a_zero_res, out_valid && out_zero_vector |->
    (out_res_x == '0 && out_res_y == '0 && out_res_z == '0), "zero vector with result")

endmodule
